// File: hdl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication
`define CHK_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// File: hdl/whc_pkg.sv
package whc_pkg;

    localparam int CordicSteps = 16;
    localparam int CordicW = 27;
    localparam int StepW = 5;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] heading;
    } whc_in_t;

    typedef struct packed {
        logic [1:0] motion_command;
        logic [1:0] phase;
        logic       aligned;
        logic       arrived;
    } whc_out_t;

    typedef enum logic [1:0] {
        CMD_STOP = 2'd0,
        CMD_CCW  = 2'd1,
        CMD_CW   = 2'd2,
        CMD_FWD  = 2'd3
    } whc_cmd_t;

    typedef enum logic [1:0] {
        PH_AIM   = 2'd0,
        PH_FINAL = 2'd1,
        PH_DONE  = 2'd2,
        PH_SPARE = 2'd3
    } whc_phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROT,
        ST_DECIDE,
        ST_OUT
    } whc_state_t;

    localparam logic [2:0] REG_TX = 3'd0;
    localparam logic [2:0] REG_TY = 3'd1;
    localparam logic [2:0] REG_FH = 3'd2;
    localparam logic [2:0] REG_DM = 3'd3;
    localparam logic [2:0] REG_HM = 3'd4;

    // arctangent of 2^-i as a 32 bit binary angle
    function automatic logic [31:0] atan_entry(input logic [StepW-1:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'd536870912;
                5'd1:  r = 32'd316933406;
                5'd2:  r = 32'd167458907;
                5'd3:  r = 32'd85004756;
                5'd4:  r = 32'd42667331;
                5'd5:  r = 32'd21354465;
                5'd6:  r = 32'd10680094;
                5'd7:  r = 32'd5340245;
                5'd8:  r = 32'd2670163;
                5'd9:  r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: hdl/waypoint_heading_controller.sv
// channel | direction | handshake         | payload
// s_      | in        | s_valid/s_ready   | whc_in_t  (pos_x, pos_y, heading)
// m_      | out       | m_valid/m_ready   | whc_out_t (command, phase, flags)
// a word's result is formed by 16 rotations of the shared cordic stage, then the
// decide state loads the result register, and m_valid is raised in the out state
// no new word is taken while one is in flight or its result is pending; the next word
// can be taken in the cycle after a result is handed over
// reset (aresetn low, synchronous) returns the phase to aim and the registers to
// their defaults; a stalled result simply holds in the output register
module waypoint_heading_controller import whc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  whc_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output whc_out_t    m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic signed [15:0] tx_reg, ty_reg, fh_reg;
    logic [14:0]        dm_reg, hm_reg;
    whc_state_t         st_reg, st_next;
    whc_phase_t         mode_reg, mode_next;
    logic signed [CordicW-1:0] cx_reg, cy_reg, cx_next, cy_next;
    logic [31:0]        acc_reg, acc_next;
    logic [StepW-1:0]   step_reg, step_next;
    logic signed [15:0] hd_reg;
    logic               arr_reg, zero_reg;
    whc_out_t           out_reg, out_next;
    logic               arr_next, zero_next;
    logic signed [16:0] dx, dy;
    logic [16:0]        adx, ady;
    logic signed [CordicW-1:0] shx, shy;
    logic [15:0]        brg, err, ferr;
    logic [16:0]        aerr, aferr;
    logic               aln;
    logic [2:0]         ridx;

    assign pready = 1'b1;
    assign ridx = paddr[4:2];

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_reg <= 16'sd1408;
            ty_reg <= -16'sd1536;
            fh_reg <= -16'sd26214;
            dm_reg <= 15'd26;
            hm_reg <= 15'd1638;
        end else if (psel && penable && pwrite) begin
            case (ridx)
                REG_TX: tx_reg <= pwdata[15:0];
                REG_TY: ty_reg <= pwdata[15:0];
                REG_FH: fh_reg <= pwdata[15:0];
                REG_DM: dm_reg <= pwdata[14:0];
                REG_HM: hm_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            REG_TX: prdata = {{16{tx_reg[15]}}, tx_reg};
            REG_TY: prdata = {{16{ty_reg[15]}}, ty_reg};
            REG_FH: prdata = {{16{fh_reg[15]}}, fh_reg};
            REG_DM: prdata = {17'd0, dm_reg};
            REG_HM: prdata = {17'd0, hm_reg};
            default: prdata = 32'd0;
        endcase
    end

    // input differences and distance box
    assign dx  = 17'(tx_reg) - 17'(s_data.pos_x);
    assign dy  = 17'(ty_reg) - 17'(s_data.pos_y);
    assign adx = dx[16] ? 17'(-dx) : dx;
    assign ady = dy[16] ? 17'(-dy) : dy;

    // shared cordic stage, arithmetic shifts floor
    assign shx = cx_reg >>> step_reg;
    assign shy = cy_reg >>> step_reg;

    // bearing rounding and heading errors
    assign brg   = zero_reg ? 16'd0 : 16'((acc_reg + 32'h8000) >> 16);
    assign err   = hd_reg - brg;
    assign ferr  = hd_reg - fh_reg;
    assign aerr  = err[15] ? 17'(-$signed({err[15], err})) : {1'b0, err};
    assign aferr = ferr[15] ? 17'(-$signed({ferr[15], ferr})) : {1'b0, ferr};
    assign aln   = aerr <= {2'b0, hm_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_IDLE;
            mode_reg <= PH_AIM;
        end else begin
            st_reg   <= st_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        acc_reg  <= acc_next;
        step_reg <= step_next;
        arr_reg  <= arr_next;
        zero_reg <= zero_next;
        out_reg  <= out_next;
        if (s_valid && s_ready) hd_reg <= s_data.heading;
    end

    // sequencer
    always_comb begin
        st_next   = st_reg;
        mode_next = mode_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        arr_next  = arr_reg;
        zero_next = zero_reg;
        out_next  = out_reg;
        s_ready   = 1'b0;
        case (st_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    arr_next  = adx <= {2'b0, dm_reg} && ady <= {2'b0, dm_reg};
                    zero_next = dx == 17'sd0 && dy == 17'sd0;
                    step_next = '0;
                    if (dx[16]) begin
                        cx_next  = -(CordicW'(dx) <<< 8);
                        cy_next  = -(CordicW'(dy) <<< 8);
                        acc_next = 32'h8000_0000;
                    end else begin
                        cx_next  = CordicW'(dx) <<< 8;
                        cy_next  = CordicW'(dy) <<< 8;
                        acc_next = 32'd0;
                    end
                    st_next = ST_ROT;
                end
            end
            ST_ROT: begin
                if (!cy_reg[CordicW-1]) begin
                    cx_next  = cx_reg + shy;
                    cy_next  = cy_reg - shx;
                    acc_next = acc_reg + atan_entry(step_reg);
                end else begin
                    cx_next  = cx_reg - shy;
                    cy_next  = cy_reg + shx;
                    acc_next = acc_reg - atan_entry(step_reg);
                end
                step_next = step_reg + 1'b1;
                if (step_reg == StepW'(CordicSteps - 1)) st_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                out_next.aligned = aln;
                out_next.arrived = arr_reg;
                out_next.motion_command = CMD_STOP;
                case (mode_reg)
                    PH_AIM: begin
                        if (!aln)
                            out_next.motion_command = (!err[15] && err != 16'd0)
                                ? CMD_CW : CMD_CCW;
                        else if (!arr_reg) out_next.motion_command = CMD_FWD;
                        else mode_next = PH_FINAL;
                    end
                    PH_FINAL: begin
                        if (aferr <= {2'b0, hm_reg}) mode_next = PH_DONE;
                        else out_next.motion_command = CMD_CCW;
                    end
                    default: mode_next = PH_DONE;
                endcase
                out_next.phase = mode_next;
                st_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    assign m_valid = st_reg == ST_OUT;
    assign m_data  = out_reg;

endmodule

// File: hdl/whc_checker.sv
`include "assert_macros.svh"
module whc_checker import whc_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input whc_out_t m_data
);
    // no new word while a result is pending
    `CHK_IMPLY(a_excl, aclk, aresetn, m_valid, !s_ready)
    // a stalled result holds
    `CHK_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // done never issues motion
    `CHK_IMPLY(a_done, aclk, aresetn, m_valid && m_data.phase == PH_DONE,
        m_data.motion_command == CMD_STOP)
    // final phase only turns ccw or stops
    `CHK_IMPLY(a_fin, aclk, aresetn, m_valid && m_data.phase == PH_FINAL,
        m_data.motion_command == CMD_CCW || m_data.motion_command == CMD_STOP)
endmodule

bind waypoint_heading_controller whc_checker u_whc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import whc_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        whc_in_t  w;
        bit       typed;
        whc_out_t want;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    whc_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    whc_out_t    m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the registers and phase
    logic signed [15:0] tgt_x = 16'sd1408;
    logic signed [15:0] tgt_y = -16'sd1536;
    logic signed [15:0] fin_hd = -16'sd26214;
    logic [14:0]        dist_m = 15'd26;
    logic [14:0]        head_m = 15'd1638;
    logic [1:0]         heading_mode = PH_AIM;

    whc_out_t expected_q[$];
    int       fails = 0;
    int       words_in = 0;
    int       words_out = 0;
    int       idle_cnt = 0;
    bit       no_idle = 1'b0;

    logic [31:0] atan_lut [16] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10680094, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861
    };

    waypoint_heading_controller dut (.*);

    always #5 aclk = ~aclk;

    // cordic bearing of (dx, dy) as Q1.15 fraction of pi
    function automatic logic signed [15:0] bearing_of(int dx, int dy);
        longint      cx, cy, nx, ny;
        logic [31:0] acc;
        logic [31:0] rnd;
        if (dx == 0 && dy == 0) return 16'sd0;
        cx = longint'(dx) * 256;
        cy = longint'(dy) * 256;
        acc = 32'd0;
        if (cx < 0) begin
            cx = -cx;
            cy = -cy;
            acc = 32'h8000_0000;
        end
        for (int i = 0; i < 16; i++) begin
            if (cy >= 0) begin
                nx = cx + (cy >>> i);
                ny = cy - (cx >>> i);
                acc = acc + atan_lut[i];
            end else begin
                nx = cx - (cy >>> i);
                ny = cy + (cx >>> i);
                acc = acc - atan_lut[i];
            end
            cx = nx;
            cy = ny;
        end
        rnd = acc + 32'h8000;
        return rnd[31:16];
    endfunction

    function automatic logic signed [15:0] bearing_at(whc_in_t w);
        return bearing_of(int'(tgt_x) - int'(w.pos_x), int'(tgt_y) - int'(w.pos_y));
    endfunction

    function automatic int mag16(logic signed [15:0] v);
        int t;
        t = v;
        return (t < 0) ? -t : t;
    endfunction

    // steering decision for one word, advances the phase
    function automatic whc_out_t steer(whc_in_t w, inout logic [1:0] m);
        int                 dx, dy, hmi, dmi;
        logic signed [15:0] err, ferr;
        whc_out_t           r;
        whc_cmd_t           cmd;
        dx = int'(tgt_x) - int'(w.pos_x);
        dy = int'(tgt_y) - int'(w.pos_y);
        hmi = head_m;
        dmi = dist_m;
        err = w.heading - bearing_of(dx, dy);
        ferr = w.heading - fin_hd;
        r.aligned = mag16(err) <= hmi;
        r.arrived = (dx < 0 ? -dx : dx) <= dmi && (dy < 0 ? -dy : dy) <= dmi;
        cmd = CMD_STOP;
        if (m == PH_AIM) begin
            if (!r.aligned) cmd = (err > 0) ? CMD_CW : CMD_CCW;
            else if (!r.arrived) cmd = CMD_FWD;
            else m = PH_FINAL;
        end else if (m == PH_FINAL) begin
            if (mag16(ferr) <= hmi) m = PH_DONE;
            else cmd = CMD_CCW;
        end else begin
            m = PH_DONE;
        end
        r.motion_command = cmd;
        r.phase = m;
        return r;
    endfunction

    task automatic send(whc_in_t w, bit typed, whc_out_t want);
        logic [1:0] m;
        whc_out_t   p;
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        m = heading_mode;
        p = steer(w, m);
        heading_mode = m;
        expected_q.push_back(typed ? want : p);
        words_in++;
        if (!no_idle && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic apb_write(logic [2:0] idx, logic [15:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_TX: tgt_x = val;
            REG_TY: tgt_y = val;
            REG_FH: fin_hd = val;
            REG_DM: dist_m = val[14:0];
            REG_HM: head_m = val[14:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (25) @(posedge aclk);
    endtask

    task automatic program_regs(logic [15:0] tx, logic [15:0] ty, logic [15:0] fh,
                                logic [15:0] dm, logic [15:0] hm);
        drain();
        apb_write(REG_TX, tx);
        apb_write(REG_TY, ty);
        apb_write(REG_FH, fh);
        apb_write(REG_DM, dm);
        apb_write(REG_HM, hm);
    endtask

    // random aim-phase word that keeps the block aiming
    task automatic aim_word();
        whc_in_t    w;
        int         span;
        logic [1:0] m;
        whc_out_t   p;
        span = int'(dist_m) + 2;
        w = 48'({$urandom, $urandom});
        if ($urandom_range(2) != 0) begin
            w.pos_x = 16'(int'(tgt_x) + $urandom_range(0, 2 * span) - span);
            w.pos_y = 16'(int'(tgt_y) + $urandom_range(0, 2 * span) - span);
        end
        if ($urandom_range(1) != 0)
            w.heading = 16'(bearing_at(w) + $urandom_range(0, 2 * (int'(head_m) + 40))
                            - (int'(head_m) + 40));
        m = heading_mode;
        p = steer(w, m);
        // an error of exactly pi is never within the margin
        if (m != PH_AIM) w.heading = bearing_at(w) ^ 16'h8000;
        send(w, 1'b0, '0);
    endtask

    // result check and ready stalls
    always @(posedge aclk) begin
        whc_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= 7);
            if (m_valid && m_ready) begin
                words_out++;
                if (expected_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected word %p", m_data);
                end else begin
                    want = expected_q.pop_front();
                    if (m_data !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("word %0d: cmd %0d/%0d phase %0d/%0d aligned %0b/%0b arrived %0b/%0b",
                                     words_out, want.motion_command, m_data.motion_command,
                                     want.phase, m_data.phase, want.aligned, m_data.aligned,
                                     want.arrived, m_data.arrived);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        dir_row_t rows[12];
        whc_in_t  w;
        int       n;
        rows = '{
            '{'{16'sd1408, -16'sd1536, 16'sh8000}, 1'b1, '{CMD_CCW, PH_AIM, 1'b0, 1'b1}},
            '{'{16'sd1152, -16'sd1536, 16'sd0}, 1'b1, '{CMD_FWD, PH_AIM, 1'b1, 1'b0}},
            '{'{16'sd1152, -16'sd1536, 16'sd4000}, 1'b1, '{CMD_CW, PH_AIM, 1'b0, 1'b0}},
            '{'{16'sd1152, -16'sd1536, -16'sd4000}, 1'b1, '{CMD_CCW, PH_AIM, 1'b0, 1'b0}},
            '{'{16'sd1152, -16'sd1536, 16'sh8000}, 1'b0, '0},
            '{'{16'sd1664, -16'sd1536, 16'sh8000}, 1'b0, '0},
            '{'{16'sd1408, -16'sd2048, 16'sd16384}, 1'b0, '0},
            '{'{16'sd1408, -16'sd1024, -16'sd16384}, 1'b0, '0},
            '{'{16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '0},
            '{'{16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0},
            '{'{16'sh8000, 16'sd32767, 16'sd0}, 1'b0, '0},
            '{'{16'sd32767, 16'sh8000, -16'sd1}, 1'b0, '0}
        };
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words at reset settings
        foreach (rows[i]) send(rows[i].w, rows[i].typed, rows[i].want);

        // random aiming under several register settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: ;
                1: program_regs(16'h7fff, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
                2: program_regs(16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
                3: program_regs(16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom_range(0, 600)), 16'($urandom_range(0, 4000)));
                default: program_regs(16'($urandom), 16'($urandom), 16'($urandom),
                                      16'($urandom), 16'($urandom));
            endcase
            no_idle = (ph == 3);
            repeat (380) aim_word();
        end

        // align on target, final turn, then done
        program_regs(16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom_range(0, 300)), 16'($urandom_range(0, 3000)));
        drain();
        w.pos_x = tgt_x;
        w.pos_y = tgt_y;
        w.heading = 16'sd0;
        send(w, 1'b0, '0);
        n = 0;
        while (heading_mode == PH_FINAL) begin
            w = 48'({$urandom, $urandom});
            if (n == 150) w.heading = fin_hd;
            else if ($urandom_range(9) == 0)
                w.heading = 16'(fin_hd + $urandom_range(0, 2 * (int'(head_m) + 8))
                                - (int'(head_m) + 8));
            else if ($urandom_range(19) == 0) w.heading = fin_hd ^ 16'h8000;
            send(w, 1'b0, '0);
            n++;
        end
        repeat (30) send(48'({$urandom, $urandom}), 1'b0, '0);

        drain();
        $display("%0d odometry words sent, %0d steering words checked", words_in, words_out);
        $display("covered aim, final turn and done phases over six register settings");
        if (fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", fails);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/whc_pkg.sv
hdl/waypoint_heading_controller.sv
hdl/whc_checker.sv
verif/testbench.sv
